### rtl/gjd_pkg.sv
package gjd_pkg;

  localparam logic [6:0]  NOWRUZ_EARLY = 7'd79;
  localparam logic [6:0]  NOWRUZ_LATE  = 7'd80;
  localparam logic [8:0]  FIRST_HALF   = 9'd186;
  localparam logic [11:0] PIVOT_YEAR   = 12'd1996;
  localparam logic [11:0] SHIFT_AFTER  = 12'd621;
  localparam logic [11:0] SHIFT_BEFORE = 12'd622;
  localparam logic [3:0]  CORR_LOW     = 4'd10;
  localparam logic [3:0]  CORR_HIGH    = 4'd11;
  localparam logic [3:0]  BASE_FIRST   = 4'd1;
  localparam logic [3:0]  BASE_SECOND  = 4'd7;
  localparam logic [3:0]  BASE_BEFORE  = 4'd10;
  localparam logic [4:0]  LEN_LONG     = 5'd31;
  localparam logic [4:0]  LEN_SHORT    = 5'd30;
  localparam logic [3:0]  MONTH_FIRST  = 4'd1;
  localparam logic [3:0]  MONTH_LAST   = 4'd12;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } clock_t;

  typedef struct packed {
    logic [11:0] year;
    logic [8:0]  date;
    logic [6:0]  offset;
    logic [3:0]  corr;
    clock_t      tm;
  } doy_t;

  typedef struct packed {
    logic [11:0] jy;
    logic [7:0]  days;
    logic        long_month;
    logic [3:0]  base;
    clock_t      tm;
  } split_t;

  typedef struct packed {
    logic [11:0] jy;
    logic [7:0]  days;
    logic        long_month;
    logic [3:0]  base;
    logic [3:0]  quot;
    clock_t      tm;
  } quot_t;

  typedef struct packed {
    logic [11:0] jy;
    logic [3:0]  jm;
    logic [4:0]  jd;
    clock_t      tm;
  } result_t;

  function automatic logic [8:0] cum_days(input logic [3:0] idx, input logic leap);
    logic [8:0] d;
    begin
      case (idx)
        4'd0:    d = 9'd0;
        4'd1:    d = 9'd31;
        4'd2:    d = 9'd59;
        4'd3:    d = 9'd90;
        4'd4:    d = 9'd120;
        4'd5:    d = 9'd151;
        4'd6:    d = 9'd181;
        4'd7:    d = 9'd212;
        4'd8:    d = 9'd243;
        4'd9:    d = 9'd273;
        4'd10:   d = 9'd304;
        4'd11:   d = 9'd334;
        default: d = 9'd334;
      endcase
      if (leap && idx >= 4'd2) begin
        d = d + 9'd1;
      end
      return d;
    end
  endfunction

endpackage

### rtl/gjd_doy.sv
module gjd_doy
  import gjd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  input  logic [11:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  clock_t      tm_in,
  output logic        valid_out,
  output doy_t        data_out
);

  logic [3:0] month_c;
  logic       leap;
  doy_t       data_next;

  always_comb begin
    if (month > MONTH_LAST) begin
      month_c = MONTH_LAST;
    end else if (month == 4'd0) begin
      month_c = MONTH_FIRST;
    end else begin
      month_c = month;
    end
    leap = (year[1:0] == 2'd0);
    data_next.year = year;
    data_next.date = cum_days(month_c - 4'd1, leap) + {4'd0, day};
    data_next.offset = (leap && year < PIVOT_YEAR) ? NOWRUZ_LATE : NOWRUZ_EARLY;
    data_next.corr = (!leap && year > PIVOT_YEAR && year[1:0] == 2'd1) ? CORR_HIGH : CORR_LOW;
    data_next.tm = tm_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    data_out <= data_next;
  end

endmodule

### rtl/gjd_split.sv
module gjd_split
  import gjd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   valid_in,
  input  doy_t   data_in,
  output logic   valid_out,
  output split_t data_out
);

  logic [8:0] after;
  logic [8:0] pre_days;
  split_t     data_next;

  always_comb begin
    after = data_in.date - {2'd0, data_in.offset};
    pre_days = data_in.date + {5'd0, data_in.corr};
    data_next.tm = data_in.tm;
    if (data_in.date > {2'd0, data_in.offset}) begin
      data_next.jy = data_in.year - SHIFT_AFTER;
      if (after <= FIRST_HALF) begin
        data_next.days = after[7:0];
        data_next.long_month = 1'b1;
        data_next.base = BASE_FIRST;
      end else begin
        data_next.days = 8'(after - FIRST_HALF);
        data_next.long_month = 1'b0;
        data_next.base = BASE_SECOND;
      end
    end else begin
      data_next.jy = data_in.year - SHIFT_BEFORE;
      data_next.days = pre_days[7:0];
      data_next.long_month = 1'b0;
      data_next.base = BASE_BEFORE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    data_out <= data_next;
  end

endmodule

### rtl/gjd_div.sv
module gjd_div
  import gjd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    valid_in,
  input  split_t  data_in,
  output logic    valid_out,
  output result_t data_out
);

  logic    q_valid;
  quot_t   q_data;
  quot_t   q_next;
  logic [4:0] len_in;
  logic [4:0] len_q;
  logic [7:0] rem;
  result_t res_next;

  // The quotient is the number of whole month lengths that fit in the day count.
  always_comb begin
    len_in = data_in.long_month ? LEN_LONG : LEN_SHORT;
    q_next.jy = data_in.jy;
    q_next.days = data_in.days;
    q_next.long_month = data_in.long_month;
    q_next.base = data_in.base;
    q_next.tm = data_in.tm;
    q_next.quot = 4'd0;
    for (int k = 1; k <= 8; k++) begin
      if ({1'b0, data_in.days} >= 9'(k * len_in)) begin
        q_next.quot = q_next.quot + 4'd1;
      end
    end
  end

  always_comb begin
    len_q = q_data.long_month ? LEN_LONG : LEN_SHORT;
    rem = q_data.days - ({4'd0, q_data.quot} * {3'd0, len_q});
    res_next.jy = q_data.jy;
    res_next.tm = q_data.tm;
    if (rem == 8'd0) begin
      res_next.jm = q_data.quot + q_data.base - 4'd1;
      res_next.jd = len_q;
    end else begin
      res_next.jm = q_data.quot + q_data.base;
      res_next.jd = rem[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      q_valid <= valid_in;
      valid_out <= q_valid;
    end
    q_data <= q_next;
    data_out <= res_next;
  end

endmodule

### rtl/gregorian_to_jalali_date.sv
// A date accepted at a clock edge passes through every register stage and shows on
// the result ports with done high for a single cycle.
// Throughput: one date per cycle; four register stages (day of year, Nowruz
// split, month quotient, month and day) carry each item with its valid bit.
// Reset is synchronous and clears the valid bits; busy is high only in reset.
module gregorian_to_jalali_date
  import gjd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] greg_year,
  input  logic [3:0]  greg_month,
  input  logic [4:0]  greg_day,
  input  logic [4:0]  hour_in,
  input  logic [5:0]  minute_in,
  input  logic [5:0]  second_in,
  input  logic [2:0]  weekday_in,
  output logic        done,
  output logic [11:0] jal_year,
  output logic [3:0]  jal_month,
  output logic [4:0]  jal_day,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out,
  output logic [2:0]  weekday_out
);

  clock_t  tm_in;
  logic    doy_valid;
  doy_t    doy_data;
  logic    split_valid;
  split_t  split_data;
  result_t res;

  assign busy = rst;
  assign tm_in = '{hour: hour_in, minute: minute_in, second: second_in, weekday: weekday_in};

  gjd_doy u_doy (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (start && !busy),
    .year      (greg_year),
    .month     (greg_month),
    .day       (greg_day),
    .tm_in     (tm_in),
    .valid_out (doy_valid),
    .data_out  (doy_data)
  );

  gjd_split u_split (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (doy_valid),
    .data_in   (doy_data),
    .valid_out (split_valid),
    .data_out  (split_data)
  );

  gjd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (split_valid),
    .data_in   (split_data),
    .valid_out (done),
    .data_out  (res)
  );

  assign jal_year    = res.jy;
  assign jal_month   = res.jm;
  assign jal_day     = res.jd;
  assign hour_out    = res.tm.hour;
  assign minute_out  = res.tm.minute;
  assign second_out  = res.tm.second;
  assign weekday_out = res.tm.weekday;

endmodule

### rtl/gjd_checker.sv
module gjd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [4:0]  hour_in,
  input logic [2:0]  weekday_in,
  input logic        done,
  input logic [3:0]  jal_month,
  input logic [4:0]  jal_day,
  input logic [4:0]  hour_out,
  input logic [2:0]  weekday_out
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##4 done)
    else $error("accepted item produced no result four cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without an accepted item");

  a_passthrough: assert property (@(posedge clk) disable iff (rst)
    done |-> hour_out == $past(hour_in, 4) && weekday_out == $past(weekday_in, 4))
    else $error("time fields not carried through");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    done |-> jal_day != 5'd0 && jal_month != 4'd0)
    else $error("month or day out of range");

endmodule

bind gregorian_to_jalali_date gjd_checker u_chk (.*);

### tb/sv/gregorian_to_jalali_date_test.sv
module gregorian_to_jalali_date_test;

  timeunit 1ns;
  timeprecision 1ps;

  import gjd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS = 380;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } jalali_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [11:0] greg_year;
  logic [3:0]  greg_month;
  logic [4:0]  greg_day;
  logic [4:0]  hour_in;
  logic [5:0]  minute_in;
  logic [5:0]  second_in;
  logic [2:0]  weekday_in;
  logic        done;
  logic [11:0] jal_year;
  logic [3:0]  jal_month;
  logic [4:0]  jal_day;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;
  logic [2:0]  weekday_out;

  int unsigned days_before_common [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  int unsigned days_before_leap [12] =
    '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};

  jalali_t pending_dates [$];
  int      mismatch_count;
  int      result_count;
  int      cycle_count;

  gregorian_to_jalali_date DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .greg_year(greg_year),
    .greg_month(greg_month),
    .greg_day(greg_day),
    .hour_in(hour_in),
    .minute_in(minute_in),
    .second_in(second_in),
    .weekday_in(weekday_in),
    .done(done),
    .jal_year(jal_year),
    .jal_month(jal_month),
    .jal_day(jal_day),
    .hour_out(hour_out),
    .minute_out(minute_out),
    .second_out(second_out),
    .weekday_out(weekday_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic jalali_t convert_date(input logic [11:0] gy, input logic [3:0] gm,
                                           input logic [4:0] gd, input logic [4:0] hh,
                                           input logic [5:0] mm, input logic [5:0] ss,
                                           input logic [2:0] wd);
    int unsigned month_idx;
    int unsigned day_of_year;
    int unsigned nowruz;
    int unsigned span;
    int unsigned len;
    int unsigned base;
    int unsigned correction;
    bit          leap;
    jalali_t     r;
    leap = (gy[1:0] == 2'b00);
    if (gm > 4'd12) begin
      month_idx = 11;
    end else if (gm == 4'd0) begin
      month_idx = 0;
    end else begin
      month_idx = gm - 1;
    end
    day_of_year = (leap ? days_before_leap[month_idx] : days_before_common[month_idx]) + gd;
    if (leap && gy < PIVOT_YEAR) begin
      nowruz = NOWRUZ_LATE;
    end else begin
      nowruz = NOWRUZ_EARLY;
    end
    if (day_of_year > nowruz) begin
      span = day_of_year - nowruz;
      if (span <= FIRST_HALF) begin
        len = LEN_LONG;
        base = BASE_FIRST;
      end else begin
        span = span - FIRST_HALF;
        len = LEN_SHORT;
        base = BASE_SECOND;
      end
      r.year = gy - SHIFT_AFTER;
    end else begin
      correction = CORR_LOW;
      if (!leap && gy > PIVOT_YEAR && gy[1:0] == 2'b01) begin
        correction = CORR_HIGH;
      end
      span = day_of_year + correction;
      len = LEN_SHORT;
      base = BASE_BEFORE;
      r.year = gy - SHIFT_BEFORE;
    end
    if (span % len == 0) begin
      r.month = 4'(span / len + base - 1);
      r.day = 5'(len);
    end else begin
      r.month = 4'(span / len + base);
      r.day = 5'(span % len);
    end
    r.hour = hh;
    r.minute = mm;
    r.second = ss;
    r.weekday = wd;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("mismatch at result %0d: %s is %0d, expected %0d", result_count, what, got,
               want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    jalali_t want;
    if (!rst && done) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result, year", jal_year, 0);
      end else begin
        want = pending_dates.pop_front();
        if (jal_year !== want.year) report_mismatch("year", jal_year, want.year);
        if (jal_month !== want.month) report_mismatch("month", jal_month, want.month);
        if (jal_day !== want.day) report_mismatch("day", jal_day, want.day);
        if (hour_out !== want.hour) report_mismatch("hour", hour_out, want.hour);
        if (minute_out !== want.minute) report_mismatch("minute", minute_out, want.minute);
        if (second_out !== want.second) report_mismatch("second", second_out, want.second);
        if (weekday_out !== want.weekday) report_mismatch("weekday", weekday_out, want.weekday);
      end
      result_count++;
    end
  end

  task automatic send_date(input logic [11:0] gy, input logic [3:0] gm, input logic [4:0] gd,
                           input logic [4:0] hh, input logic [5:0] mm, input logic [5:0] ss,
                           input logic [2:0] wd);
    start <= 1'b1;
    greg_year <= gy;
    greg_month <= gm;
    greg_day <= gd;
    hour_in <= hh;
    minute_in <= mm;
    second_in <= ss;
    weekday_in <= wd;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_dates.push_back(convert_date(gy, gm, gd, hh, mm, ss, wd));
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) begin
        greg_year <= 12'($urandom);
        greg_month <= 4'($urandom);
        greg_day <= 5'($urandom);
        @(posedge clk);
      end
    end
  endtask

  task automatic wait_for_results;
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_date;
    logic [11:0] gy;
    logic [3:0]  gm;
    logic [4:0]  gd;
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [5:0]  ss;
    logic [2:0]  wd;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      gy = 12'($urandom_range(0, 4095));
    end else if (pick <= 3) begin
      gy = 12'($urandom_range(1990, 2010));
    end else begin
      gy = 12'($urandom_range(623, 4095));
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      gm = 4'($urandom_range(0, 15));
      gd = 5'($urandom_range(0, 31));
    end else if (pick <= 2) begin
      gm = 4'd3;
      gd = 5'($urandom_range(15, 25));
    end else begin
      gm = 4'($urandom_range(1, 12));
      gd = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 28));
    end
    if ($urandom_range(0, 7) == 0) begin
      hh = 5'($urandom);
      mm = 6'($urandom);
      ss = 6'($urandom);
      wd = 3'($urandom);
    end else begin
      hh = 5'($urandom_range(0, 23));
      mm = 6'($urandom_range(0, 59));
      ss = 6'($urandom_range(0, 59));
      wd = 3'($urandom_range(0, 6));
    end
    send_date(gy, gm, gd, hh, mm, ss, wd);
  endtask

  task automatic test_year_extremes;
    send_date(12'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd0);
    send_date(12'd622, 4'd6, 5'd15, 5'd23, 6'd59, 6'd59, 3'd6);
    send_date(12'd623, 4'd1, 5'd1, 5'd12, 6'd30, 6'd30, 3'd3);
    send_date(12'd4095, 4'd12, 5'd31, 5'd31, 6'd63, 6'd63, 3'd7);
    send_date(12'd4095, 4'd1, 5'd1, 5'd1, 6'd1, 6'd1, 3'd1);
  endtask

  task automatic test_nowruz_edges;
    send_date(12'd1995, 4'd3, 5'd20, 5'd8, 6'd0, 6'd0, 3'd1);
    send_date(12'd1995, 4'd3, 5'd21, 5'd8, 6'd0, 6'd0, 3'd2);
    send_date(12'd1992, 4'd3, 5'd20, 5'd8, 6'd0, 6'd0, 3'd3);
    send_date(12'd1992, 4'd3, 5'd21, 5'd8, 6'd0, 6'd0, 3'd4);
    send_date(12'd2000, 4'd3, 5'd19, 5'd8, 6'd0, 6'd0, 3'd5);
    send_date(12'd2000, 4'd3, 5'd20, 5'd8, 6'd0, 6'd0, 3'd6);
    send_date(12'd1997, 4'd1, 5'd1, 5'd8, 6'd0, 6'd0, 3'd0);
    send_date(12'd2001, 4'd3, 5'd20, 5'd8, 6'd0, 6'd0, 3'd1);
    send_date(12'd1993, 4'd3, 5'd20, 5'd8, 6'd0, 6'd0, 3'd2);
  endtask

  task automatic test_month_splits;
    send_date(12'd2003, 4'd4, 5'd20, 5'd10, 6'd5, 6'd5, 3'd0);
    send_date(12'd2003, 4'd9, 5'd22, 5'd10, 6'd5, 6'd5, 3'd1);
    send_date(12'd2003, 4'd9, 5'd23, 5'd10, 6'd5, 6'd5, 3'd2);
    send_date(12'd2004, 4'd12, 5'd31, 5'd10, 6'd5, 6'd5, 3'd3);
    send_date(12'd2003, 4'd12, 5'd31, 5'd10, 6'd5, 6'd5, 3'd4);
  endtask

  task automatic test_out_of_range_fields;
    send_date(12'd2010, 4'd0, 5'd10, 5'd0, 6'd0, 6'd0, 3'd0);
    send_date(12'd2010, 4'd13, 5'd10, 5'd31, 6'd63, 6'd63, 3'd7);
    send_date(12'd2012, 4'd15, 5'd31, 5'd24, 6'd60, 6'd60, 3'd7);
    send_date(12'd2010, 4'd5, 5'd0, 5'd1, 6'd2, 6'd3, 3'd4);
    send_date(12'd2011, 4'd2, 5'd31, 5'd1, 6'd2, 6'd3, 3'd5);
    send_date(12'd1000, 4'd1, 5'd0, 5'd1, 6'd2, 6'd3, 3'd6);
  endtask

  task automatic test_pause_until_drained;
    repeat (10) send_random_date();
    wait_for_results();
    repeat (10) send_random_date();
  endtask

  task automatic test_random_dates(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && sent < count) begin
        send_random_date();
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_cycles($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    mismatch_count = 0;
    result_count = 0;
    rst <= 1'b1;
    start <= 1'b0;
    greg_year <= '0;
    greg_month <= '0;
    greg_day <= '0;
    hour_in <= '0;
    minute_in <= '0;
    second_in <= '0;
    weekday_in <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_year_extremes();
    test_nowruz_edges();
    idle_cycles(3);
    test_month_splits();
    test_out_of_range_fields();
    test_pause_until_drained();
    test_random_dates(RANDOM_ITEMS);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### gregorian_to_jalali_date.f
rtl/gjd_pkg.sv
rtl/gjd_doy.sv
rtl/gjd_split.sv
rtl/gjd_div.sv
rtl/gregorian_to_jalali_date.sv
rtl/gjd_checker.sv
tb/sv/gregorian_to_jalali_date_test.sv
